FILE: rtl/tcm_pkg.sv
// ----------------------------------------------------------------------------
// tcm_pkg
// Shared types, constants and rounding for the twiddle complex multiplier.
// ----------------------------------------------------------------------------
package tcm_pkg;

    localparam int IDX_W  = 12;
    localparam int DATA_W = 16;

    // pi with 60 fraction bits, cut down to Q2.30 scale for the ROM builder
    localparam logic [63:0] PI_Q30   = 64'h3243F6A8885A308D >> 30;
    localparam logic [63:0] ONE_Q30  = 64'h0000_0000_4000_0000;
    localparam logic [63:0] HALF_Q30 = 64'h0000_0000_2000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } cplx_t;

    // Round half up from Q.15 and saturate to 16 bits
    function automatic logic signed [DATA_W-1:0] round_sat16(input logic signed [32:0] v);
        logic signed [33:0] s;
        logic signed [18:0] q;
        s = 34'(v) + 34'sd16384;
        q = 19'(s >>> 15);
        if (q > 19'sd32767)
            return 16'sh7FFF;
        else if (q < -19'sd32768)
            return 16'sh8000;
        else
            return q[DATA_W-1:0];
    endfunction

endpackage

FILE: rtl/tcm_split.sv
// ----------------------------------------------------------------------------
// tcm_split
// Divides the twiddle index by SPLIT through a reciprocal multiply.
// ----------------------------------------------------------------------------
module tcm_split #(
    parameter int SPLIT = 2048
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [tcm_pkg::IDX_W-1:0]  phase_index,
    output logic                       valid,
    output logic [tcm_pkg::IDX_W-1:0]  idx,
    output logic [((((2**tcm_pkg::IDX_W)-1)/SPLIT) > 0 ?
                   $clog2((((2**tcm_pkg::IDX_W)-1)/SPLIT)+1) : 1)-1:0] quot
);

    localparam int IW     = tcm_pkg::IDX_W;
    localparam int CDEPTH = (((2**IW) - 1) / SPLIT) + 1;
    localparam int QW     = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int K      = IW + $clog2(SPLIT);
    localparam int unsigned RECIP = ((2**K) + SPLIT - 1) / SPLIT;

    logic [IW+K-1:0] prod;
    logic            valid_reg;
    logic [IW-1:0]   idx_reg;
    logic [QW-1:0]   quot_reg;

    // exact floor for every 12-bit index since 2^K >= 4096 * SPLIT
    assign prod = (IW+K)'(phase_index) * (IW+K)'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= phase_index;
        quot_reg <= prod[K +: QW];
    end

    assign valid = valid_reg;
    assign idx   = idx_reg;
    assign quot  = quot_reg;

endmodule

FILE: rtl/tcm_rom.sv
// ----------------------------------------------------------------------------
// tcm_rom
// Fine and coarse twiddle ROMs, contents built at elaboration, registered read.
// ----------------------------------------------------------------------------
module tcm_rom #(
    parameter int LENGTH = 4096,
    parameter int SPLIT  = 2048
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [tcm_pkg::IDX_W-1:0]  idx,
    input  logic [((((2**tcm_pkg::IDX_W)-1)/SPLIT) > 0 ?
                   $clog2((((2**tcm_pkg::IDX_W)-1)/SPLIT)+1) : 1)-1:0] quot,
    output logic                       valid,
    output logic                       bypass,
    output tcm_pkg::cplx_t             fine,
    output tcm_pkg::cplx_t             coarse
);

    localparam int IW     = tcm_pkg::IDX_W;
    localparam int FDEPTH = (SPLIT < (2**IW)) ? SPLIT : (2**IW);
    localparam int FW     = $clog2(FDEPTH);
    localparam int CDEPTH = (((2**IW) - 1) / SPLIT) + 1;
    localparam int QW     = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

    typedef logic [(2**FW)-1:0][31:0] fine_rom_t;
    typedef logic [(2**QW)-1:0][31:0] coarse_rom_t;

    function automatic logic [63:0] tstep(input logic [63:0] term, input logic [63:0] x2);
        return (term * x2 + tcm_pkg::HALF_Q30) >> 30;
    endfunction

    function automatic logic signed [15:0] to_q15(input logic [63:0] v30);
        logic [63:0] v;
        v = (v30 + 64'd16384) >> 15;
        return (v > 64'd32767) ? 16'sd32767 : v[15:0];
    endfunction

    // {cos, sin} in Q1.15 of 2*pi*n/LENGTH
    function automatic logic [31:0] rom_entry(input logic [63:0] n);
        logic [63:0] t, r, x, x2, term, sn, cs;
        logic [2:0]  oct;
        logic signed [15:0] c0, s0, cq, sq, c, s;
        t = (((n % 64'(LENGTH)) << 32) + 64'(LENGTH / 2)) / 64'(LENGTH);
        t = t & 64'h0000_0000_FFFF_FFFF;
        oct = t[31:29];
        r = {35'd0, t[28:0]};
        if (oct[0])
            r = 64'h2000_0000 - r;
        x  = (r * tcm_pkg::PI_Q30 + tcm_pkg::ONE_Q30) >> 31;
        x2 = (x * x + tcm_pkg::HALF_Q30) >> 30;
        // sine series to x^13
        term = x;
        sn   = x;
        term = tstep(term, x2) / 64'd6;   sn = sn - term;
        term = tstep(term, x2) / 64'd20;  sn = sn + term;
        term = tstep(term, x2) / 64'd42;  sn = sn - term;
        term = tstep(term, x2) / 64'd72;  sn = sn + term;
        term = tstep(term, x2) / 64'd110; sn = sn - term;
        term = tstep(term, x2) / 64'd156; sn = sn + term;
        // cosine series to x^12
        term = tcm_pkg::ONE_Q30;
        cs   = tcm_pkg::ONE_Q30;
        term = tstep(term, x2) / 64'd2;   cs = cs - term;
        term = tstep(term, x2) / 64'd12;  cs = cs + term;
        term = tstep(term, x2) / 64'd30;  cs = cs - term;
        term = tstep(term, x2) / 64'd56;  cs = cs + term;
        term = tstep(term, x2) / 64'd90;  cs = cs - term;
        term = tstep(term, x2) / 64'd132; cs = cs + term;
        c0 = to_q15(cs);
        s0 = to_q15(sn);
        if (oct[0])
        begin
            cq = s0;
            sq = c0;
        end
        else
        begin
            cq = c0;
            sq = s0;
        end
        unique case (oct[2:1])
            2'd0:
            begin
                c = cq;
                s = sq;
            end
            2'd1:
            begin
                c = -sq;
                s = cq;
            end
            2'd2:
            begin
                c = -cq;
                s = -sq;
            end
            default:
            begin
                c = sq;
                s = -cq;
            end
        endcase
        return {c, s};
    endfunction

    function automatic fine_rom_t build_fine();
        fine_rom_t rom;
        rom = '0;
        for (int a = 0; a < (2**FW); a++)
            rom[a] = rom_entry(64'(a));
        return rom;
    endfunction

    function automatic coarse_rom_t build_coarse();
        coarse_rom_t rom;
        rom = '0;
        for (int k = 0; k < (2**QW); k++)
            rom[k] = rom_entry(64'(k) * 64'(SPLIT));
        return rom;
    endfunction

    localparam fine_rom_t   FINE_ROM   = build_fine();
    localparam coarse_rom_t COARSE_ROM = build_coarse();

    logic [IW-1:0]  base;
    logic [IW-1:0]  rem;
    logic           valid_reg;
    logic           bypass_reg;
    logic [31:0]    fine_reg;
    logic [31:0]    coarse_reg;

    assign base = IW'(32'(quot) * 32'(SPLIT));
    assign rem  = idx - base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        fine_reg   <= FINE_ROM[rem[FW-1:0]];
        coarse_reg <= COARSE_ROM[quot];
        // coarse entry only joins in above the first SPLIT indices
        bypass_reg <= !((LENGTH > SPLIT) && (quot != '0));
    end

    assign valid     = valid_reg;
    assign bypass    = bypass_reg;
    assign fine.re   = fine_reg[31:16];
    assign fine.im   = fine_reg[15:0];
    assign coarse.re = coarse_reg[31:16];
    assign coarse.im = coarse_reg[15:0];

endmodule

FILE: rtl/tcm_cmul.sv
// ----------------------------------------------------------------------------
// tcm_cmul
// Two-stage complex multiply with round half up and 16-bit saturation, or a pass-through of a when bypass is set.
// ----------------------------------------------------------------------------
module tcm_cmul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            bypass,
    input  tcm_pkg::cplx_t  a,
    input  tcm_pkg::cplx_t  b,
    output logic            valid,
    output tcm_pkg::cplx_t  y
);

    logic                v1_reg;
    logic                v2_reg;
    logic                bypass_reg;
    tcm_pkg::cplx_t      a_reg;
    logic signed [31:0]  p_rr_reg;
    logic signed [31:0]  p_ii_reg;
    logic signed [31:0]  p_ri_reg;
    logic signed [31:0]  p_ir_reg;
    tcm_pkg::cplx_t      y_next;
    tcm_pkg::cplx_t      y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_rr_reg   <= $signed(a.re) * $signed(b.re);
        p_ii_reg   <= $signed(a.im) * $signed(b.im);
        p_ri_reg   <= $signed(a.re) * $signed(b.im);
        p_ir_reg   <= $signed(a.im) * $signed(b.re);
        a_reg      <= a;
        bypass_reg <= bypass;
        y_reg      <= y_next;
    end

    always_comb
    begin
        if (bypass_reg)
            y_next = a_reg;
        else
        begin
            y_next.re = tcm_pkg::round_sat16(33'(p_rr_reg) - 33'(p_ii_reg));
            y_next.im = tcm_pkg::round_sat16(33'(p_ri_reg) + 33'(p_ir_reg));
        end
    end

    assign valid = v2_reg;
    assign y     = y_reg;

endmodule

FILE: rtl/twiddle_complex_multiply.sv
// ----------------------------------------------------------------------------
// twiddle_complex_multiply
// Rotates a complex sample by exp(2*pi*i*index/LENGTH) from two twiddle ROMs.
// ----------------------------------------------------------------------------
// Usage:
//   A beat enters when start is high and busy is low. busy is never raised:
//   the pipeline takes one beat every clock, so a full FFT stream runs
//   through at one sample per cycle.
//   sample_real/sample_imag are 16-bit signed; phase_index picks the twiddle.
//   After a beat is taken, done pulses for one cycle with
//   product_real/product_imag valid in that cycle.
//   Stages: index divide (reciprocal multiply), ROM read, fine x coarse
//   product, round/saturate, sample x twiddle product, round/saturate into
//   the output register. Below SPLIT the fine entry passes straight through.
//   The result must be taken in the cycle done is high; there is no back
//   pressure, so nothing is ever held or dropped inside.
//   Reset clears the valid bits only; no clearing pass, ROMs are constant.
// ----------------------------------------------------------------------------
module twiddle_complex_multiply #(
    parameter int LENGTH = 4096,
    parameter int SPLIT  = 2048
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [tcm_pkg::DATA_W-1:0] sample_real,
    input  logic signed [tcm_pkg::DATA_W-1:0] sample_imag,
    input  logic [tcm_pkg::IDX_W-1:0]         phase_index,
    output logic                              done,
    output logic signed [tcm_pkg::DATA_W-1:0] product_real,
    output logic signed [tcm_pkg::DATA_W-1:0] product_imag
);

    localparam int IW     = tcm_pkg::IDX_W;
    localparam int CDEPTH = (((2**IW) - 1) / SPLIT) + 1;
    localparam int QW     = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int SDLY   = 4;

    logic            in_fire;
    logic            v_split;
    logic [IW-1:0]   idx_split;
    logic [QW-1:0]   quot_split;
    logic            v_rom;
    logic            bypass_rom;
    tcm_pkg::cplx_t  fine_rom;
    tcm_pkg::cplx_t  coarse_rom;
    logic            v_tw;
    tcm_pkg::cplx_t  twiddle;
    logic            v_out;
    tcm_pkg::cplx_t  product;
    tcm_pkg::cplx_t  samp_in;
    tcm_pkg::cplx_t  samp_reg [SDLY];

    assign busy    = 1'b0;
    assign in_fire = start && !busy;

    assign samp_in.re = sample_real;
    assign samp_in.im = sample_imag;

    // sample rides alongside the twiddle path until the final multiply
    always_ff @(posedge clk)
    begin
        samp_reg[0] <= samp_in;
        for (int i = 1; i < SDLY; i++)
            samp_reg[i] <= samp_reg[i-1];
    end

    tcm_split #(
        .SPLIT (SPLIT)
    ) u_split (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_fire),
        .phase_index (phase_index),
        .valid       (v_split),
        .idx         (idx_split),
        .quot        (quot_split)
    );

    tcm_rom #(
        .LENGTH (LENGTH),
        .SPLIT  (SPLIT)
    ) u_rom (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v_split),
        .idx      (idx_split),
        .quot     (quot_split),
        .valid    (v_rom),
        .bypass   (bypass_rom),
        .fine     (fine_rom),
        .coarse   (coarse_rom)
    );

    tcm_cmul u_tw_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v_rom),
        .bypass   (bypass_rom),
        .a        (fine_rom),
        .b        (coarse_rom),
        .valid    (v_tw),
        .y        (twiddle)
    );

    tcm_cmul u_samp_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v_tw),
        .bypass   (1'b0),
        .a        (samp_reg[SDLY-1]),
        .b        (twiddle),
        .valid    (v_out),
        .y        (product)
    );

    assign done         = v_out;
    assign product_real = product.re;
    assign product_imag = product.im;

    // every beat taken comes out on done at the end of the pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> ##6 done)
        else $error("accepted beat did not produce a result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_fire, 6))
        else $error("result without a matching beat");

    a_zero_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && sample_real == '0 && sample_imag == '0)
            |-> ##6 (product_real == '0 && product_imag == '0))
        else $error("zero sample gave a non-zero product");

    a_tw_align: assert property (@(posedge clk) disable iff (!rst_n)
        v_tw |-> $past(v_split, 3))
        else $error("twiddle valid out of step with index stage");

endmodule
